// ===== design/sxf_pkg.sv =====
package sxf_pkg;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_FLD = 8'h1C;

  localparam logic [7:0] SEQ_FIRST = 8'h81;
  localparam logic [7:0] SEQ_LAST  = 8'hFF;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_A    = 8'd65;
  localparam logic [3:0] NIBBLE_MAX = 4'd15;

  localparam logic [1:0] ACT_DATA      = 2'd0;
  localparam logic [1:0] ACT_FIELD     = 2'd1;
  localparam logic [1:0] ACT_FRAME_END = 2'd2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    POS_STX  = 3'd0,
    POS_SEQ  = 3'd1,
    POS_BODY = 3'd2,
    POS_HEX0 = 3'd3,
    POS_HEX1 = 3'd4,
    POS_HEX2 = 3'd5,
    POS_HEX3 = 3'd6
  } pos_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       reserved_flag;
  } result_t;

  typedef struct packed {
    logic        hdr;
    logic [7:0]  seq;
    logic        frame_end;
    logic [7:0]  body;
    logic        reserved;
    logic [15:0] checksum;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] hex_ascii(input logic [3:0] v);
    logic [7:0] wide;
    wide = {4'h0, v & NIBBLE_MAX};
    return (v < 4'd10) ? (ASCII_ZERO + wide) : (ASCII_A - 8'd10 + wide);
  endfunction

  function automatic logic is_reserved(input logic [7:0] b);
    return (b == BYTE_STX) || (b == BYTE_ETX) || (b == BYTE_ESC) || (b == BYTE_FLD);
  endfunction

endpackage

// ===== design/sxf_front.sv =====
module sxf_front import sxf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  item_t     item,
  input  q_status_t q_status,
  output logic      push,
  output entry_t    push_entry
);

  logic [7:0]  seq_value;
  logic [7:0]  seq_value_next;
  logic        frame_open;
  logic [15:0] running_sum;
  logic [15:0] sum_next;
  logic [15:0] hdr_sum;
  logic [7:0]  body;
  logic        act_ok;
  logic        accept;

  assign item_stall = q_status.full;
  assign accept     = item_valid && !q_status.full;

  always_comb begin
    act_ok = 1'b1;
    body   = item.data_byte;
    unique case (item.action)
      ACT_DATA:      body = item.data_byte;
      ACT_FIELD:     body = BYTE_FLD;
      ACT_FRAME_END: body = BYTE_ETX;
      default:       act_ok = 1'b0;
    endcase
  end

  always_comb begin
    if (seq_value < SEQ_FIRST || seq_value >= SEQ_LAST) begin
      seq_value_next = SEQ_FIRST;
    end else begin
      seq_value_next = seq_value + 8'd1;
    end
  end

  assign hdr_sum  = frame_open ? 16'h0000 : ({8'h00, BYTE_STX} + {8'h00, seq_value});
  assign sum_next = (frame_open ? running_sum : 16'h0000) + hdr_sum + {8'h00, body};

  assign push = accept && act_ok;

  always_comb begin
    push_entry.hdr       = !frame_open;
    push_entry.seq       = seq_value;
    push_entry.frame_end = (item.action == ACT_FRAME_END);
    push_entry.body      = body;
    push_entry.reserved  = (item.action == ACT_DATA) && is_reserved(item.data_byte);
    push_entry.checksum  = sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_value   <= SEQ_FIRST;
      frame_open  <= 1'b0;
      running_sum <= 16'h0000;
    end else if (push) begin
      if (!frame_open) begin
        seq_value <= seq_value_next;
      end
      if (item.action == ACT_FRAME_END) begin
        frame_open  <= 1'b0;
        running_sum <= 16'h0000;
      end else begin
        frame_open  <= 1'b1;
        running_sum <= sum_next;
      end
    end
  end

endmodule

// ===== design/sxf_queue.sv =====
module sxf_queue import sxf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  entry_t    push_entry,
  input  logic      pop,
  output entry_t    head,
  output q_status_t q_status
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign q_status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== design/sxf_back.sv =====
module sxf_back import sxf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  entry_t    head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      result_valid,
  input  logic      result_stall,
  output result_t   result
);

  logic    active;
  pos_t    pos;
  pos_t    pos_cur;
  pos_t    pos_last;
  logic    out_free;
  logic    fire;
  logic    at_last;
  result_t res_next;

  assign out_free = !result_valid || !result_stall;
  assign fire     = out_free && !q_status.empty;
  assign pos_cur  = active ? pos : (head.hdr ? POS_STX : POS_BODY);
  assign pos_last = head.frame_end ? POS_HEX3 : POS_BODY;
  assign at_last  = (pos_cur == pos_last);
  assign pop      = fire && at_last;

  always_comb begin
    res_next.last_of_run   = at_last;
    res_next.reserved_flag = 1'b0;
    unique case (pos_cur)
      POS_STX:  res_next.out_byte = BYTE_STX;
      POS_SEQ:  res_next.out_byte = head.seq;
      POS_BODY: begin
        res_next.out_byte      = head.body;
        res_next.reserved_flag = head.reserved;
      end
      POS_HEX0: res_next.out_byte = hex_ascii(head.checksum[15:12]);
      POS_HEX1: res_next.out_byte = hex_ascii(head.checksum[11:8]);
      POS_HEX2: res_next.out_byte = hex_ascii(head.checksum[7:4]);
      POS_HEX3: res_next.out_byte = hex_ascii(head.checksum[3:0]);
      default:  res_next.out_byte = BYTE_STX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      pos          <= POS_STX;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        active <= !at_last;
        pos    <= pos_t'(pos_cur + 3'd1);
      end
      if (out_free) begin
        result_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= res_next;
    end
  end

endmodule

// ===== design/stx_etx_framer_hex_checksum.sv =====
// An accepted item's entry is registered in the queue, then its first byte on the output.
// Throughput while result_stall is low: one output byte per cycle; one item per cycle
// while each item makes one byte. Frame headers (two bytes) and trailers (ETX plus four
// hex digits) leave a four-entry queue at that rate; the front stalls only if it is full.
// Reset (rst, synchronous) empties the queue, closes any frame and sets the sequence to 0x81.
module stx_etx_framer_hex_checksum import sxf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  q_status_t q_status;
  logic      push;
  entry_t    push_entry;
  logic      pop;
  entry_t    head;

  sxf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  sxf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  sxf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
